FILE: src/i2d_pkg.sv
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared constants, types and helpers for the binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int VALUE_BITS    = 32;
  localparam int BCD_BITS      = 4;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  // decimal digits needed for an unsigned word of wb bits (log10(2) ~ 0.30103)
  function automatic int num_digits(input int wb);
    return (wb * 30103) / 100000 + 1;
  endfunction

  typedef struct packed {
    logic clear;
    logic conv;
    logic dshift;
  } i2d_ctrl_t;

endpackage

FILE: src/i2d_cell.sv
// ----------------------------------------------------------------------------
// i2d_cell
// One BCD digit of the conversion chain: add-3 and shift during conversion,
// digit hand-over toward the top during output.
// ----------------------------------------------------------------------------
module i2d_cell (
  input  logic              clk,
  input  i2d_pkg::i2d_ctrl_t ctrl,
  input  logic              cin,
  input  logic [3:0]        din,
  output logic              cout,
  output logic [3:0]        digit
);
  import i2d_pkg::*;

  logic [BCD_BITS-1:0] digit_r;
  logic [BCD_BITS-1:0] digit_nxt;
  logic [BCD_BITS-1:0] adj;

  assign adj   = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign cout  = adj[3];
  assign digit = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.conv) begin
      digit_nxt = {adj[2:0], cin};
    end else if (ctrl.dshift) begin
      digit_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

FILE: src/i2d_chain.sv
// ----------------------------------------------------------------------------
// i2d_chain
// Row of BCD cells; binary bits enter at the bottom, digits leave at the top.
// ----------------------------------------------------------------------------
module i2d_chain #(
  parameter int NDIG = 10
) (
  input  logic               clk,
  input  i2d_pkg::i2d_ctrl_t ctrl,
  input  logic               bit_in,
  output logic [3:0]         top_digit,
  output logic               overflow
);
  import i2d_pkg::*;

  logic [NDIG:0]        carry;
  logic [BCD_BITS-1:0]  digits [NDIG];

  assign carry[0] = bit_in;

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic [BCD_BITS-1:0] din;
    if (i == 0) begin : g_bottom
      assign din = '0;
    end else begin : g_upper
      assign din = digits[i-1];
    end
    i2d_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .cin   (carry[i]),
      .din   (din),
      .cout  (carry[i+1]),
      .digit (digits[i])
    );
  end

  assign top_digit = digits[NDIG-1];
  assign overflow  = carry[NDIG] & ctrl.conv;

endmodule

FILE: src/int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// Converts a word to ASCII decimal, optional minus sign, no leading zeros.
// ----------------------------------------------------------------------------
//   channel | direction | fields                 | handshake
//   in_     | input     | value, signed_mode     | in_valid / in_stall
//   out_    | output    | character, last        | out_valid / out_stall
//
// One transaction loads the word, shifts its WORD_BITS bits through the
// BCD cell chain, skips leading zero digits, then emits the characters in
// order (sign, digits). The shift-add chain is the limit: one binary bit
// enters per cycle.
// Reset clears control state and the output valid. out_stall holds the
// output register and pauses sign and digit emission; a new input is taken
// as soon as the final character is registered.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_unit #(
  parameter int WORD_BITS = i2d_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  input  logic        in_signed_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import i2d_pkg::*;

  localparam int NDIG   = num_digits(WORD_BITS);
  localparam int CNT_W  = $clog2(WORD_BITS + 1);
  localparam int REM_W  = $clog2(NDIG + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_MINUS = 3'd2;
  localparam logic [2:0] S_SKIP  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [WORD_BITS-1:0] shreg_r, shreg_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [WORD_BITS-1:0] word_w;
  logic [WORD_BITS-1:0] mag_w;
  logic                 neg_w;
  logic                 accept;
  logic                 slot_free;
  logic [3:0]           top_digit;
  logic                 overflow;
  i2d_ctrl_t            ctrl;

  if (WORD_BITS > VALUE_BITS) begin : g_wide
    assign word_w = {{(WORD_BITS - VALUE_BITS){1'b0}}, in_value};
  end else if (WORD_BITS == VALUE_BITS) begin : g_equal
    assign word_w = in_value;
  end else begin : g_narrow
    assign word_w = in_value[WORD_BITS-1:0];
  end

  assign neg_w     = in_signed_mode & word_w[WORD_BITS-1];
  assign mag_w     = neg_w ? ('0 - word_w) : word_w;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign slot_free = ~out_valid_r | ~out_stall;

  i2d_chain #(.NDIG(NDIG)) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (shreg_r[WORD_BITS-1]),
    .top_digit (top_digit),
    .overflow  (overflow)
  );

  always_comb begin
    state_nxt     = state_r;
    shreg_nxt     = shreg_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctrl.clear = 1'b1;
          shreg_nxt  = mag_w;
          neg_nxt    = neg_w;
          cnt_nxt    = CNT_W'(WORD_BITS);
          rem_nxt    = REM_W'(NDIG);
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.conv = 1'b1;
        shreg_nxt = shreg_r << 1;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = neg_r ? S_MINUS : S_SKIP;
        end
      end
      S_MINUS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = MINUS_CHAR;
          out_last_nxt  = 1'b0;
          state_nxt     = S_SKIP;
        end
      end
      S_SKIP: begin
        if ((top_digit == 4'd0) && (rem_r > REM_W'(1))) begin
          ctrl.dshift = 1'b1;
          rem_nxt     = rem_r - REM_W'(1);
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          ctrl.dshift   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = DIGIT_ZERO | {4'd0, top_digit};
          out_last_nxt  = (rem_r == REM_W'(1));
          rem_nxt       = rem_r - REM_W'(1);
          if (rem_r == REM_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    shreg_r    <= shreg_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == MINUS_CHAR) ||
                    ((out_char_r >= DIGIT_ZERO) && (out_char_r <= DIGIT_NINE)))
    else $error("output character outside sign and digit set");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == MINUS_CHAR)) |-> !out_last_r)
    else $error("minus sign marked as last character");

  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CONV))
    else $error("accepted transaction did not start conversion");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !overflow)
    else $error("BCD chain overflowed its top cell");

  a_digit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGIT) |-> (rem_r != '0))
    else $error("digit emission with no digits remaining");

endmodule
